### sv/cge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the conflict graph edge insert block
// no dependencies

package cge_pkg;

    localparam int NUM_VARS      = 1024;
    localparam int EDGE_CAPACITY = 4096;
    localparam int NODE_COUNT    = 2 * NUM_VARS;
    localparam int VAR_W         = 10;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int EDGE_W        = $clog2(EDGE_CAPACITY + 1);
    localparam int EIDX_W        = $clog2(EDGE_CAPACITY);
    localparam int COUNT_W       = 13;
    localparam int ADDED_W       = 3;
    localparam logic [EDGE_W-1:0] NIL = EDGE_W'(EDGE_CAPACITY);

    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;

    // which pair of nodes the datapath is working on
    typedef enum logic [1:0] {
        SEL_N1 = 2'd0,
        SEL_C1 = 2'd1,
        SEL_N2 = 2'd2,
        SEL_C2 = 2'd3
    } node_sel_t;

    typedef struct packed {
        logic      load;       // latch a new item
        logic      head_rd;    // read head of src node
        node_sel_t src;
        node_sel_t dst;
        logic      walk_rd;    // read edge at cursor
        logic      cur_from_head;
        logic      insert;     // prepend src->dst
        logic      set_full;
        logic      clr_head;   // write empty marker at clear address
    } dp_cmd_t;

    typedef struct packed {
        logic item_ok;         // graph not full when item latched
        logic has_conflict;    // kind selects a conflict edge and vars differ
        logic head_empty;      // head read data is empty marker
        logic room;            // an edge slot is free
        logic cur_end;         // walk cursor past end
        logic hit;             // edge at cursor targets dst
        logic clr_last;        // clear address at last node
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/cge_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// datapath: item registers, head store, edge stores, counters
// depends on cge_pkg

module cge_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [cge_pkg::VAR_W-1:0]       instantiated_var,
    input  wire logic                            instantiated_value,
    input  wire logic [cge_pkg::VAR_W-1:0]       fixed_var,
    input  wire logic [1:0]                      fixed_kind,
    input  wire cge_pkg::dp_cmd_t                cmd,
    output cge_pkg::dp_stat_t                    stat,
    output logic [cge_pkg::COUNT_W-1:0]          edge_count,
    output logic                                 full_res,
    output logic [cge_pkg::ADDED_W-1:0]          edges_added
);

    localparam int NW = cge_pkg::NODE_W;
    localparam int EW = cge_pkg::EDGE_W;
    localparam int IW = cge_pkg::EIDX_W;

    logic [NW-1:0] n1_reg, c1_reg, n2_reg, c2_reg;
    logic          ok_reg, conf_reg;
    logic [EW-1:0] stored_reg;
    logic          full_reg;
    logic [cge_pkg::ADDED_W-1:0] added_reg;
    logic [EW-1:0] cur_reg;
    logic [EW-1:0] head_q_reg;
    logic [EW-1:0] next_q_reg;
    logic [NW-1:0] tgt_q_reg;
    logic          rd_valid_reg;
    logic [NW-1:0] clr_addr_reg;

    // head store, set to the empty marker by a clearing pass after reset
    logic [EW-1:0] head_mem [cge_pkg::NODE_COUNT];
    logic [EW-1:0] next_mem [cge_pkg::EDGE_CAPACITY];
    logic [NW-1:0] tgt_mem  [cge_pkg::EDGE_CAPACITY];

    logic [NW-1:0] src_node, dst_node;

    function automatic logic [NW-1:0] pick(input cge_pkg::node_sel_t s,
        input logic [NW-1:0] a, input logic [NW-1:0] b,
        input logic [NW-1:0] c, input logic [NW-1:0] d);
        logic [NW-1:0] r;
        unique case (s)
            cge_pkg::SEL_N1: r = a;
            cge_pkg::SEL_C1: r = b;
            cge_pkg::SEL_N2: r = c;
            cge_pkg::SEL_C2: r = d;
            default:         r = a;
        endcase
        return r;
    endfunction

    assign src_node = pick(cmd.src, n1_reg, c1_reg, n2_reg, c2_reg);
    assign dst_node = pick(cmd.dst, n1_reg, c1_reg, n2_reg, c2_reg);

    // item decode
    logic [NW-1:0] n1_next, c1_next, n2_next, c2_next;
    logic          conf_next;
    always_comb
    begin
        if (instantiated_value)
        begin
            n1_next = {1'b0, instantiated_var};
            c1_next = {1'b1, instantiated_var};
        end
        else
        begin
            n1_next = {1'b1, instantiated_var};
            c1_next = {1'b0, instantiated_var};
        end
        if (fixed_kind == cge_pkg::KIND_UPPER)
        begin
            n2_next = {1'b1, fixed_var};
            c2_next = {1'b0, fixed_var};
        end
        else
        begin
            n2_next = {1'b0, fixed_var};
            c2_next = {1'b1, fixed_var};
        end
        conf_next = (fixed_var != instantiated_var) &&
                    ((fixed_kind == cge_pkg::KIND_UPPER) ||
                     (fixed_kind == cge_pkg::KIND_LOWER));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n1_reg   <= n1_next;
            c1_reg   <= c1_next;
            n2_reg   <= n2_next;
            c2_reg   <= c2_next;
            conf_reg <= conf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= 1'b0;
            stored_reg <= '0;
            full_reg  <= 1'b0;
            added_reg <= '0;
            cur_reg   <= cge_pkg::NIL;
            rd_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clr_head)
                clr_addr_reg <= clr_addr_reg + NW'(1);
            if (cmd.load)
            begin
                ok_reg    <= !full_reg;
                added_reg <= '0;
            end
            if (cmd.set_full)
                full_reg <= 1'b1;
            rd_valid_reg <= cmd.walk_rd;
            if (cmd.cur_from_head)
                cur_reg <= head_q_reg;
            else if (rd_valid_reg)
                cur_reg <= next_q_reg;
            if (cmd.insert)
            begin
                stored_reg <= stored_reg + EW'(1);
                added_reg  <= added_reg + cge_pkg::ADDED_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
            head_q_reg <= head_mem[src_node];
        if (cmd.clr_head)
            head_mem[clr_addr_reg] <= cge_pkg::NIL;
        else if (cmd.insert)
            head_mem[src_node] <= stored_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_rd)
        begin
            next_q_reg <= next_mem[cur_reg[IW-1:0]];
            tgt_q_reg  <= tgt_mem[cur_reg[IW-1:0]];
        end
        if (cmd.insert)
        begin
            next_mem[stored_reg[IW-1:0]] <= head_q_reg;
            tgt_mem[stored_reg[IW-1:0]]  <= dst_node;
        end
    end

    always_comb
    begin
        stat.item_ok      = ok_reg;
        stat.has_conflict = conf_reg;
        stat.head_empty   = !(head_q_reg < cge_pkg::NIL);
        stat.room         = stored_reg < cge_pkg::NIL;
        stat.cur_end      = !(cur_reg < stored_reg);
        // target data stays valid from the read until the compare state
        stat.hit          = (tgt_q_reg == dst_node);
        stat.clr_last     = (clr_addr_reg == NW'(cge_pkg::NODE_COUNT - 1));
    end

    assign edge_count  = stored_reg[cge_pkg::COUNT_W-1:0];
    assign full_res    = full_reg;
    assign edges_added = added_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= cge_pkg::NIL)
        else $error("edge count beyond capacity");
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (stored_reg < cge_pkg::NIL))
        else $error("insert with no room");
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(full_reg) |-> full_reg)
        else $error("full flag cleared");

endmodule

`default_nettype wire

### sv/cge_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// controller: sequences complement links, list walks and inserts
// depends on cge_pkg

module cge_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output cge_pkg::dp_cmd_t       cmd,
    input  wire cge_pkg::dp_stat_t stat
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_HEAD  = 9'b0_0000_0010,   // head read issued
        S_CHECK = 9'b0_0000_0100,   // head data ready
        S_WLOAD = 9'b0_0000_1000,   // cursor loaded from head
        S_WRD   = 9'b0_0001_0000,   // edge read issued
        S_WCHK  = 9'b0_0010_0000,   // compare target
        S_NEXT  = 9'b0_0100_0000,
        S_DONE  = 9'b0_1000_0000,
        S_INIT  = 9'b1_0000_0000    // head store clearing pass
    } state_t;

    // steps: 0 n1->c1, 1 c1->n1, 2 n2->c2, 3 c2->n2, 4 n1->n2, 5 n2->n1
    logic [2:0] step_reg, step_next;
    state_t     state_reg, state_next;

    logic is_walk;
    assign is_walk = step_reg[2];

    always_comb
    begin
        cmd = '0;
        unique case (step_reg)
            3'd0: begin cmd.src = cge_pkg::SEL_N1; cmd.dst = cge_pkg::SEL_C1; end
            3'd1: begin cmd.src = cge_pkg::SEL_C1; cmd.dst = cge_pkg::SEL_N1; end
            3'd2: begin cmd.src = cge_pkg::SEL_N2; cmd.dst = cge_pkg::SEL_C2; end
            3'd3: begin cmd.src = cge_pkg::SEL_C2; cmd.dst = cge_pkg::SEL_N2; end
            3'd4: begin cmd.src = cge_pkg::SEL_N1; cmd.dst = cge_pkg::SEL_N2; end
            default: begin cmd.src = cge_pkg::SEL_N2; cmd.dst = cge_pkg::SEL_N1; end
        endcase
        state_next = state_reg;
        step_next  = step_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_head = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    step_next = 3'd0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!stat.item_ok)
                    state_next = S_DONE;
                else
                begin
                    cmd.head_rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (is_walk)
                begin
                    cmd.cur_from_head = 1'b1;
                    state_next = S_WLOAD;
                end
                else if (!stat.head_empty)
                    state_next = S_NEXT;
                else if (stat.room)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.set_full = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_WLOAD, S_WCHK:
            begin
                if (state_reg == S_WCHK && stat.hit)
                    state_next = S_NEXT;
                else if (stat.cur_end)
                begin
                    if (stat.room)
                    begin
                        cmd.insert = 1'b1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        cmd.set_full = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next = S_WRD;
                end
            end
            S_WRD:
                state_next = S_WCHK;
            S_NEXT:
            begin
                if (step_reg == 3'd5 || (step_reg == 3'd1 && !stat.has_conflict))
                    state_next = S_DONE;
                else
                begin
                    step_next = step_reg + 3'd1;
                    state_next = S_HEAD;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("double done");
    a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (step_reg <= 3'd5))
        else $error("insert at bad step");
    a_walk_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_rd |-> is_walk)
        else $error("walk outside conflict step");

endmodule

`default_nettype wire

### sv/conflict_graph_edge_insert_core.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the conflict graph edge insert block
// depends on cge_pkg, cge_ctrl, cge_datapath

// An item is taken when start is high and busy is low; its single result
// appears on edge_count, full_res and edges_added with done high for one
// cycle, and the receiver cannot stall it. After reset busy stays high
// while all 2048 head store entries are cleared to the empty marker. An
// item with a conflict edge walks the two adjacency lists one edge at a
// time through the single read port on the edge store; an item with only
// complement links walks no list, and an item on a full graph ends without
// reading the head store. A new item can be taken in the cycle after done.

module conflict_graph_edge_insert_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [cge_pkg::VAR_W-1:0]       instantiated_var,
    input  wire logic                            instantiated_value,
    input  wire logic [cge_pkg::VAR_W-1:0]       fixed_var,
    input  wire logic [1:0]                      fixed_kind,
    output logic                                 done,
    output logic [cge_pkg::COUNT_W-1:0]          edge_count,
    output logic                                 full_res,
    output logic [cge_pkg::ADDED_W-1:0]          edges_added
);

    cge_pkg::dp_cmd_t  cmd;
    cge_pkg::dp_stat_t stat;

    cge_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    cge_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .instantiated_var   (instantiated_var),
        .instantiated_value (instantiated_value),
        .fixed_var          (fixed_var),
        .fixed_kind         (fixed_kind),
        .cmd                (cmd),
        .stat               (stat),
        .edge_count         (edge_count),
        .full_res           (full_res),
        .edges_added        (edges_added)
    );

endmodule

`default_nettype wire

### tb/conflict_graph_edge_insert_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for conflict_graph_edge_insert_core: random and directed items,
// an in-bench graph predictor, and a scoreboard over the single result per item
// depends on cge_pkg and the core

module conflict_graph_edge_insert_core_tb;

    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [cge_pkg::VAR_W-1:0] ivar;
        logic                      ival;
        logic [cge_pkg::VAR_W-1:0] fvar;
        logic [1:0]                kind;
    } probe_item_t;

    typedef struct packed {
        logic [cge_pkg::COUNT_W-1:0] count;
        logic                        full;
        logic [cge_pkg::ADDED_W-1:0] added;
    } graph_status_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [cge_pkg::VAR_W-1:0] instantiated_var;
    logic instantiated_value;
    logic [cge_pkg::VAR_W-1:0] fixed_var;
    logic [1:0] fixed_kind;
    logic done;
    logic [cge_pkg::COUNT_W-1:0] edge_count;
    logic full_res;
    logic [cge_pkg::ADDED_W-1:0] edges_added;

    conflict_graph_edge_insert_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .instantiated_var(instantiated_var), .instantiated_value(instantiated_value),
        .fixed_var(fixed_var), .fixed_kind(fixed_kind), .done(done),
        .edge_count(edge_count), .full_res(full_res), .edges_added(edges_added)
    );

    // predictor state
    int unsigned lit_head [cge_pkg::NODE_COUNT];
    int unsigned lnk_next [cge_pkg::EDGE_CAPACITY];
    int unsigned lnk_dest [cge_pkg::EDGE_CAPACITY];
    int unsigned n_edges;
    bit          is_full;
    int unsigned n_added;

    probe_item_t   pending_items[$];
    graph_status_t expected_status[$];
    int  errors;
    int  cycle_cnt;
    int  send_idle_pct;
    bit  hold_send;

    function automatic bit lit_empty(int unsigned node);
        return node >= cge_pkg::NODE_COUNT || lit_head[node] >= cge_pkg::EDGE_CAPACITY;
    endfunction

    function automatic bit push_edge(int unsigned src, int unsigned dst);
        if (n_edges >= cge_pkg::EDGE_CAPACITY)
        begin
            is_full = 1'b1;
            return 1'b0;
        end
        lnk_dest[n_edges] = dst;
        lnk_next[n_edges] = lit_head[src];
        lit_head[src] = n_edges;
        n_edges++;
        n_added++;
        return 1'b1;
    endfunction

    function automatic bit edge_present(int unsigned src, int unsigned dst);
        int unsigned e;
        e = lit_head[src];
        while (e < cge_pkg::EDGE_CAPACITY && e < n_edges)
        begin
            if (lnk_dest[e] == dst)
                return 1'b1;
            e = lnk_next[e];
        end
        return 1'b0;
    endfunction

    function automatic bit pair_with_complement(int unsigned lit, int unsigned comp);
        if (lit_empty(lit) && !push_edge(lit, comp))
            return 1'b0;
        if (lit_empty(comp) && !push_edge(comp, lit))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic graph_status_t insert_conflict(probe_item_t it);
        graph_status_t r;
        int unsigned n1, c1, n2, c2;
        logic [1:0] k;
        bit ok;
        n_added = 0;
        k = it.kind;
        if (!is_full)
        begin
            n1 = it.ival ? it.ivar : cge_pkg::NUM_VARS + it.ivar;
            c1 = it.ival ? cge_pkg::NUM_VARS + it.ivar : it.ivar;
            if (it.fvar == it.ivar)
                k = 2'd0;
            if (pair_with_complement(n1, c1)
                && (k == cge_pkg::KIND_UPPER || k == cge_pkg::KIND_LOWER))
            begin
                n2 = (k == cge_pkg::KIND_UPPER) ? cge_pkg::NUM_VARS + it.fvar : it.fvar;
                c2 = (k == cge_pkg::KIND_UPPER) ? it.fvar : cge_pkg::NUM_VARS + it.fvar;
                if (pair_with_complement(n2, c2))
                begin
                    ok = 1'b1;
                    if (!edge_present(n1, n2))
                        ok = push_edge(n1, n2);
                    if (ok && !edge_present(n2, n1))
                        void'(push_edge(n2, n1));
                end
            end
        end
        r.count = cge_pkg::COUNT_W'(n_edges);
        r.full  = is_full;
        r.added = cge_pkg::ADDED_W'(n_added);
        return r;
    endfunction

    function automatic probe_item_t mk_item(int iv, int ivl, int fv, int k);
        probe_item_t it;
        it.ivar = cge_pkg::VAR_W'(iv);
        it.ival = ivl[0];
        it.fvar = cge_pkg::VAR_W'(fv);
        it.kind = k[1:0];
        return it;
    endfunction

    // random item, mostly on a small pool so lists grow and duplicates are found
    function automatic probe_item_t rand_item();
        int iv, fv;
        if ($urandom_range(99) < 80)
        begin
            iv = $urandom_range(40);
            fv = $urandom_range(40);
        end
        else
        begin
            iv = $urandom_range(1023);
            fv = $urandom_range(1023);
        end
        return mk_item(iv, $urandom_range(1), fv,
                       ($urandom_range(9) < 8) ? $urandom_range(1, 2) : $urandom_range(3));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // item acceptance and next drive happen at the falling edge, after the edge settles
    bit taken;
    always @(posedge clk)
        taken <= rst_n && start && !busy;

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            if (taken)
            begin
                expected_status.push_back(insert_conflict(pending_items.pop_front()));
            end
            if (pending_items.size() != 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                instantiated_var   <= pending_items[0].ivar;
                instantiated_value <= pending_items[0].ival;
                fixed_var          <= pending_items[0].fvar;
                fixed_kind         <= pending_items[0].kind;
                start              <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        graph_status_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && done)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: result with nothing expected: count %0d full %0d added %0d",
                         $time, edge_count, full_res, edges_added);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (edge_count !== want.count)
                begin
                    $display("%0t: edge_count expected %0d actual %0d", $time, want.count,
                             edge_count);
                    errors++;
                end
                if (full_res !== want.full)
                begin
                    $display("%0t: full_res expected %0d actual %0d", $time, want.full,
                             full_res);
                    errors++;
                end
                if (edges_added !== want.added)
                begin
                    $display("%0t: edges_added expected %0d actual %0d", $time, want.added,
                             edges_added);
                    errors++;
                end
            end
        end
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || start || taken || expected_status.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int i, ph;
        errors = 0;
        cycle_cnt = 0;
        hold_send = 1'b0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        instantiated_var = '0;
        instantiated_value = 1'b0;
        fixed_var = '0;
        fixed_kind = 2'd0;
        foreach (lit_head[j])
            lit_head[j] = cge_pkg::EDGE_CAPACITY;
        n_edges = 0;
        is_full = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every kind, same variable, duplicates
        pending_items.push_back(mk_item(0, 0, 1023, cge_pkg::KIND_UPPER));
        pending_items.push_back(mk_item(0, 0, 1023, cge_pkg::KIND_UPPER));
        pending_items.push_back(mk_item(1023, 1, 0, cge_pkg::KIND_LOWER));
        pending_items.push_back(mk_item(1023, 1, 0, cge_pkg::KIND_LOWER));
        pending_items.push_back(mk_item(5, 1, 5, cge_pkg::KIND_UPPER));
        pending_items.push_back(mk_item(6, 0, 7, 0));
        pending_items.push_back(mk_item(8, 1, 9, 3));
        pending_items.push_back(mk_item(682, 0, 341, cge_pkg::KIND_LOWER));
        pending_items.push_back(mk_item(341, 1, 682, cge_pkg::KIND_UPPER));
        pending_items.push_back(mk_item(0, 1, 1023, cge_pkg::KIND_LOWER));
        pending_items.push_back(mk_item(1023, 0, 0, cge_pkg::KIND_UPPER));
        wait_drained();

        // pause until drained, then four random phases with sender idling of 0, 70, 0 and 29 percent
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 29 : 0;
            for (i = 0; i < 110; i++)
                pending_items.push_back(rand_item());
            wait_drained();
        end
        repeat (300) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
sv/cge_pkg.sv
sv/cge_datapath.sv
sv/cge_ctrl.sv
sv/conflict_graph_edge_insert_core.sv
tb/conflict_graph_edge_insert_core_tb.sv
